### hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the look-direction block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition never occurs outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

### hw/rtl/ypld_pkg.sv
// Package with types, constants and helper functions of the look-direction block.
`timescale 1ns / 1ps
`default_nettype none

package ypld_pkg;

   // Sizing
   localparam int CORDIC_STEPS = 16;
   localparam int POS_BITS     = 16;
   localparam int CORDIC_ITERS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
   localparam int ITER_W       = $clog2(CORDIC_ITERS);
   localparam int POS_USE      = (POS_BITS < 16) ? POS_BITS : 16;

   // Field and datapath widths
   localparam int CMD_W   = 2;
   localparam int VAL_W   = 16;
   localparam int GAIN_W  = 16;
   localparam int YAW_W   = 15;
   localparam int PITCH_W = 14;
   localparam int DIR_W   = 16;
   localparam int OFS_W   = 15;
   localparam int OPD_W   = 17;
   localparam int MUL_W   = 34;
   localparam int SUM_W   = 16;
   localparam int ZW      = 25;
   localparam int XYW     = 33;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // Angle constants in 1/64 degree
   localparam int ANG_HALF    = 11520;
   localparam int ANG_FULL    = 23040;
   localparam int ANG_QUARTER = 5760;
   localparam int PITCH_LIM   = 5696;
   localparam int Q15_MAX     = 32767;
   localparam int CORDIC_K    = 652032874;

   // Offset rounding
   localparam int CURSOR_RND   = 32;
   localparam int CURSOR_SHIFT = 6;
   localparam int STICK_RND    = 16384;
   localparam int STICK_SHIFT  = 15;

   // Reset values
   localparam int CURSOR_GAIN_RST = 410;
   localparam int STICK_GAIN_RST  = 4096;
   localparam int YAW_RST         = -5760;
   localparam int PITCH_RST       = 0;

   // Queue sizing
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Arctangent table sizing
   localparam int ATAN_DEPTH = 24;
   localparam int ATAN_IDX_W = $clog2(ATAN_DEPTH);

   // atan(2^-i) in 1/65536 degree
   localparam logic [21:0] ATAN_TABLE [ATAN_DEPTH] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
      22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
      22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
      22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
   };

   typedef enum logic [CMD_W-1:0] {
      CMD_CURSOR   = 2'd0,
      CMD_STICK    = 2'd1,
      CMD_SET_LAST = 2'd2,
      CMD_REFRESH  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CURSOR_GAIN = 2'd0,
      CSR_STICK_GAIN  = 2'd1,
      CSR_START_YAW   = 2'd2,
      CSR_START_PITCH = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      OP_CURSOR,
      OP_STICK,
      OP_HOLD
   } op_type;

   // Classified work item handed from front to back
   typedef struct packed {
      op_type                   op;
      logic signed [OPD_W-1:0]  opd_x;
      logic signed [OPD_W-1:0]  opd_y;
   } work_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic full;
      logic empty;
   } q_stat_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cord_stat_type;

   typedef struct packed {
      logic [GAIN_W-1:0]         cursor_gain;
      logic [GAIN_W-1:0]         stick_gain;
      logic                      load_yaw;
      logic                      load_pitch;
      logic signed [YAW_W-1:0]   start_yaw;
      logic signed [PITCH_W-1:0] start_pitch;
   } cfg_type;

   // Round a Q2.30 value to Q1.15, ties up, and clamp to +-32767
   function automatic logic signed [DIR_W-1:0] round_q15(input logic signed [XYW-1:0] v);
      logic signed [XYW:0]    sum;
      logic signed [XYW-15:0] shr;
      sum = (XYW+1)'(v) + (XYW+1)'(STICK_RND);
      shr = sum[XYW:15];
      if (shr > Q15_MAX) begin
         return DIR_W'(Q15_MAX);
      end else if (shr < -Q15_MAX) begin
         return DIR_W'(-Q15_MAX);
      end else begin
         return shr[DIR_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

### hw/rtl/ypld_if.sv
// Channel interfaces of the look-direction block: command, result and register write.
`timescale 1ns / 1ps
`default_nettype none

interface ypld_req_if import ypld_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        cmd;
   logic signed [VAL_W-1:0] x_value;
   logic signed [VAL_W-1:0] y_value;

   modport source(output valid, output cmd, output x_value, output y_value, input ready);
   modport sink(input valid, input cmd, input x_value, input y_value, output ready);
endinterface

interface ypld_rsp_if import ypld_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [YAW_W-1:0]   yaw_out;
   logic signed [PITCH_W-1:0] pitch_out;
   logic signed [DIR_W-1:0]   dir_x;
   logic signed [DIR_W-1:0]   dir_y;
   logic signed [DIR_W-1:0]   dir_z;

   modport source(output valid, output yaw_out, output pitch_out, output dir_x,
                  output dir_y, output dir_z, input ready);
   modport sink(input valid, input yaw_out, input pitch_out, input dir_x,
                input dir_y, input dir_z, output ready);
endinterface

interface ypld_csr_if import ypld_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/ypld_front.sv
// Front end: accepts commands, tracks the cursor position and classifies work items.
`timescale 1ns / 1ps
`default_nettype none

module ypld_front import ypld_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   ypld_req_if.sink req,
   input  logic     q_full,
   output logic     push,
   output work_type push_data
);

   logic signed [VAL_W-1:0] last_x_ff, last_x_in;
   logic signed [VAL_W-1:0] last_y_ff, last_y_in;
   logic                    first_ff, first_in;
   logic signed [VAL_W-1:0] pos_x, pos_y, base_x, base_y;
   logic                    accept;

   // Reduce a raw value to the configured position width
   function automatic logic signed [VAL_W-1:0] to_pos(input logic signed [VAL_W-1:0] v);
      logic signed [VAL_W-1:0] t;
      t = v <<< (VAL_W - POS_USE);
      return t >>> (VAL_W - POS_USE);
   endfunction

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;
   assign push      = accept;

   // Positions and deltas; the first move measures from itself
   always_comb begin
      pos_x  = to_pos(req.x_value);
      pos_y  = to_pos(req.y_value);
      base_x = first_ff ? pos_x : last_x_ff;
      base_y = first_ff ? pos_y : last_y_ff;
   end

   // Classify the transaction and update the cursor tracking state
   always_comb begin
      last_x_in       = last_x_ff;
      last_y_in       = last_y_ff;
      first_in        = first_ff;
      push_data.op    = OP_HOLD;
      push_data.opd_x = '0;
      push_data.opd_y = '0;
      unique case (cmd_type'(req.cmd))
         CMD_CURSOR: begin
            push_data.op    = OP_CURSOR;
            push_data.opd_x = OPD_W'(pos_x) - OPD_W'(base_x);
            push_data.opd_y = OPD_W'(base_y) - OPD_W'(pos_y);
            last_x_in       = pos_x;
            last_y_in       = pos_y;
            first_in        = 1'b0;
         end
         CMD_STICK: begin
            push_data.op    = OP_STICK;
            push_data.opd_x = OPD_W'(req.x_value);
            push_data.opd_y = -OPD_W'(req.y_value);
         end
         CMD_SET_LAST: begin
            last_x_in = pos_x;
            last_y_in = pos_y;
         end
         CMD_REFRESH: begin
            push_data.op = OP_HOLD;
         end
         default: begin
            push_data.op = OP_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff <= '0;
         last_y_ff <= '0;
         first_ff  <= 1'b1;
      end else if (accept) begin
         last_x_ff <= last_x_in;
         last_y_ff <= last_y_in;
         first_ff  <= first_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/ypld_queue.sv
// Short queue of classified work items between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module ypld_queue import ypld_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  work_type   push_data,
   input  logic       pop,
   output work_type   pop_data,
   output q_stat_type stat
);

   work_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                do_push, do_pop;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign stat.push  = push;
   assign stat.pop   = pop;
   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_data   = entry_ff[rd_ptr_ff];

   // Store payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

### hw/rtl/ypld_cordic.sv
// Iterative CORDIC unit: cosine and sine of an angle in 1/64 degree, Q1.15 results.
`timescale 1ns / 1ps
`default_nettype none

module ypld_cordic import ypld_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [YAW_W-1:0] angle,
   output cord_stat_type           stat,
   output logic signed [DIR_W-1:0] cos_q15,
   output logic signed [DIR_W-1:0] sin_q15
);

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_RUN,
      CS_ROUND
   } cord_state_type;

   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERS - 1);

   cord_state_type          state_ff;
   logic signed [XYW-1:0]   x_ff, y_ff, x_in, y_in;
   logic signed [ZW-1:0]    z_ff, z_in, z_start, atan_val;
   logic [ITER_W-1:0]       cnt_ff;
   logic [ATAN_IDX_W-1:0]   atan_idx;
   logic                    flip_ff, flip_start, done_ff;
   logic signed [SUM_W-1:0] a_wide, a_red, a_quad;
   logic signed [XYW-1:0]   x_shr, y_shr;
   logic signed [DIR_W-1:0] cos_ff, sin_ff;

   assign stat.busy = (state_ff != CS_IDLE);
   assign stat.done = done_ff;
   assign cos_q15   = cos_ff;
   assign sin_q15   = sin_ff;

   // Fold the angle into one turn and then into the right half plane
   always_comb begin
      a_wide     = SUM_W'(angle);
      flip_start = 1'b0;
      if (a_wide > ANG_HALF) begin
         a_red = a_wide - SUM_W'(ANG_FULL);
      end else if (a_wide < -ANG_HALF) begin
         a_red = a_wide + SUM_W'(ANG_FULL);
      end else begin
         a_red = a_wide;
      end
      if (a_red > ANG_QUARTER) begin
         a_quad     = a_red - SUM_W'(ANG_HALF);
         flip_start = 1'b1;
      end else if (a_red < -ANG_QUARTER) begin
         a_quad     = a_red + SUM_W'(ANG_HALF);
         flip_start = 1'b1;
      end else begin
         a_quad = a_red;
      end
      z_start = ZW'(a_quad) <<< 10;
   end

   // One micro-rotation
   always_comb begin
      x_shr    = x_ff >>> cnt_ff;
      y_shr    = y_ff >>> cnt_ff;
      atan_idx = ATAN_IDX_W'(cnt_ff);
      atan_val = $signed(ZW'(ATAN_TABLE[atan_idx]));
      if (!z_ff[ZW-1]) begin
         x_in = x_ff - y_shr;
         y_in = y_ff + x_shr;
         z_in = z_ff - atan_val;
      end else begin
         x_in = x_ff + y_shr;
         y_in = y_ff - x_shr;
         z_in = z_ff + atan_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            CS_IDLE: begin
               if (start) begin
                  x_ff     <= XYW'(CORDIC_K);
                  y_ff     <= '0;
                  z_ff     <= z_start;
                  flip_ff  <= flip_start;
                  cnt_ff   <= '0;
                  state_ff <= CS_RUN;
               end
            end
            CS_RUN: begin
               x_ff   <= x_in;
               y_ff   <= y_in;
               z_ff   <= z_in;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == ITER_LAST) begin
                  state_ff <= CS_ROUND;
               end
            end
            CS_ROUND: begin
               cos_ff   <= round_q15(flip_ff ? -x_ff : x_ff);
               sin_ff   <= round_q15(flip_ff ? -y_ff : y_ff);
               done_ff  <= 1'b1;
               state_ff <= CS_IDLE;
            end
            default: begin
               state_ff <= CS_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### hw/rtl/ypld_back.sv
// Back end: scales offsets, updates yaw and pitch, sequences the CORDIC and drives results.
`timescale 1ns / 1ps
`default_nettype none

module ypld_back import ypld_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  work_type                pop_data,
   input  logic                    q_empty,
   output logic                    pop,
   output logic                    cord_start,
   output logic signed [YAW_W-1:0] cord_angle,
   input  cord_stat_type           cord_stat,
   input  logic signed [DIR_W-1:0] cord_cos,
   input  logic signed [DIR_W-1:0] cord_sin,
   ypld_rsp_if.source              rsp
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_SCALE_Y,
      ST_APPLY,
      ST_YAW,
      ST_PITCH,
      ST_PROD_X,
      ST_PROD_Z,
      ST_FINISH
   } back_state_type;

   back_state_type            state_ff;
   work_type                  work_ff;
   logic signed [MUL_W-1:0]   prod_ff, prod_in;
   logic signed [OFS_W-1:0]   ofs_x_ff, ofs_y_ff;
   logic signed [YAW_W-1:0]   yaw_ff;
   logic signed [PITCH_W-1:0] pitch_ff;
   logic signed [DIR_W-1:0]   cy_ff, sy_ff, dir_x_ff, dir_z_ff;
   logic                      start_ff;
   logic                      rsp_valid_ff;
   logic signed [YAW_W-1:0]   rsp_yaw_ff;
   logic signed [PITCH_W-1:0] rsp_pitch_ff;
   logic signed [DIR_W-1:0]   rsp_dx_ff, rsp_dy_ff, rsp_dz_ff;
   logic [GAIN_W-1:0]         gain;
   logic signed [OPD_W-1:0]   opd;
   logic signed [SUM_W-1:0]   yaw_sum, pitch_sum;
   logic signed [YAW_W-1:0]   yaw_in;
   logic signed [PITCH_W-1:0] pitch_in;
   logic signed [2*DIR_W-1:0] dir_prod;
   logic                      out_free;

   // Round a scaled offset and saturate it to half a turn
   function automatic logic signed [OFS_W-1:0] scale_offset(
      input logic signed [MUL_W-1:0] prod, input op_type op);
      logic signed [MUL_W-1:0] rnd;
      if (op == OP_CURSOR) begin
         rnd = (prod + MUL_W'(CURSOR_RND)) >>> CURSOR_SHIFT;
      end else begin
         rnd = (prod + MUL_W'(STICK_RND)) >>> STICK_SHIFT;
      end
      if (rnd > ANG_HALF) begin
         return OFS_W'(ANG_HALF);
      end else if (rnd < -ANG_HALF) begin
         return OFS_W'(-ANG_HALF);
      end else begin
         return rnd[OFS_W-1:0];
      end
   endfunction

   assign pop        = (state_ff == ST_IDLE) && !q_empty;
   assign cord_start = start_ff;
   assign cord_angle = (state_ff == ST_YAW) ? yaw_ff : YAW_W'(pitch_ff);
   assign out_free   = !rsp_valid_ff || rsp.ready;

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.yaw_out   = rsp_yaw_ff;
   assign rsp.pitch_out = rsp_pitch_ff;
   assign rsp.dir_x     = rsp_dx_ff;
   assign rsp.dir_y     = rsp_dy_ff;
   assign rsp.dir_z     = rsp_dz_ff;

   // Shared offset multiplier
   always_comb begin
      gain    = (work_ff.op == OP_CURSOR) ? cfg.cursor_gain : cfg.stick_gain;
      opd     = (state_ff == ST_MUL_X) ? work_ff.opd_x : work_ff.opd_y;
      prod_in = MUL_W'(opd) * MUL_W'($signed({1'b0, gain}));
   end

   // Yaw wraps once, pitch clamps
   always_comb begin
      yaw_sum   = SUM_W'(yaw_ff) + SUM_W'(ofs_x_ff);
      pitch_sum = SUM_W'(pitch_ff) + SUM_W'(ofs_y_ff);
      if (yaw_sum > ANG_HALF) begin
         yaw_in = YAW_W'(yaw_sum - SUM_W'(ANG_FULL));
      end else if (yaw_sum < -ANG_HALF) begin
         yaw_in = YAW_W'(yaw_sum + SUM_W'(ANG_FULL));
      end else begin
         yaw_in = yaw_sum[YAW_W-1:0];
      end
      if (pitch_sum > PITCH_LIM) begin
         pitch_in = PITCH_W'(PITCH_LIM);
      end else if (pitch_sum < -PITCH_LIM) begin
         pitch_in = PITCH_W'(-PITCH_LIM);
      end else begin
         pitch_in = pitch_sum[PITCH_W-1:0];
      end
   end

   // Direction product: cos(yaw) or sin(yaw) times cos(pitch)
   always_comb begin
      dir_prod = ((state_ff == ST_PROD_X) ? cy_ff : sy_ff) * cord_cos;
   end

   // Sequencer with angle state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         yaw_ff       <= YAW_W'(YAW_RST);
         pitch_ff     <= PITCH_W'(PITCH_RST);
      end else begin
         start_ff <= 1'b0;
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  work_ff <= pop_data;
                  if (pop_data.op == OP_HOLD) begin
                     start_ff <= 1'b1;
                     state_ff <= ST_YAW;
                  end else begin
                     state_ff <= ST_MUL_X;
                  end
               end
            end
            ST_MUL_X: begin
               prod_ff  <= prod_in;
               state_ff <= ST_MUL_Y;
            end
            ST_MUL_Y: begin
               ofs_x_ff <= scale_offset(prod_ff, work_ff.op);
               prod_ff  <= prod_in;
               state_ff <= ST_SCALE_Y;
            end
            ST_SCALE_Y: begin
               ofs_y_ff <= scale_offset(prod_ff, work_ff.op);
               state_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               yaw_ff   <= yaw_in;
               pitch_ff <= pitch_in;
               start_ff <= 1'b1;
               state_ff <= ST_YAW;
            end
            ST_YAW: begin
               if (cord_stat.done) begin
                  cy_ff    <= cord_cos;
                  sy_ff    <= cord_sin;
                  start_ff <= 1'b1;
                  state_ff <= ST_PITCH;
               end
            end
            ST_PITCH: begin
               if (cord_stat.done) begin
                  state_ff <= ST_PROD_X;
               end
            end
            ST_PROD_X: begin
               dir_x_ff <= round_q15(XYW'(dir_prod));
               state_ff <= ST_PROD_Z;
            end
            ST_PROD_Z: begin
               dir_z_ff <= round_q15(XYW'(dir_prod));
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_yaw_ff   <= yaw_ff;
                  rsp_pitch_ff <= pitch_ff;
                  rsp_dx_ff    <= dir_x_ff;
                  rsp_dy_ff    <= cord_sin;
                  rsp_dz_ff    <= dir_z_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         // Load start angles from register writes
         if (cfg.load_yaw) begin
            yaw_ff <= cfg.start_yaw;
         end
         if (cfg.load_pitch) begin
            pitch_ff <= cfg.start_pitch;
         end
      end
   end

endmodule

`default_nettype wire

### hw/rtl/yaw_pitch_look_direction_top.sv
// Top level of the look-direction block: register file, front, queue, back and CORDIC.
//
//   port      dir    role
//   req_bus   sink   command transaction: cmd, x_value, y_value
//   rsp_bus   source result transaction: yaw_out, pitch_out, dir_x, dir_y, dir_z
//   csr_bus   sink   register write transaction: index, data
//
// Each command runs the one CORDIC unit in the back end, for yaw then pitch; cursor and
// joystick moves first pass through the multiply, scale and apply states.
// The front accepts a transaction per cycle while the two-entry queue has room.
// A finished result waits in the output register; the back end stalls only then.
// Reset is synchronous and needs no clearing pass; register writes complete at once.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module yaw_pitch_look_direction_top import ypld_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ypld_req_if.sink   req_bus,
   ypld_rsp_if.source rsp_bus,
   ypld_csr_if.sink   csr_bus
);

   logic [GAIN_W-1:0]       cursor_gain_ff, stick_gain_ff;
   logic                    csr_write;
   cfg_type                 cfg;
   logic                    push, pop;
   work_type                push_data, pop_data;
   q_stat_type              q_stat;
   logic                    cord_start;
   logic signed [YAW_W-1:0] cord_angle;
   cord_stat_type           cord_stat;
   logic signed [DIR_W-1:0] cord_cos, cord_sin;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid;

   // Decode register writes
   always_comb begin
      cfg.cursor_gain = cursor_gain_ff;
      cfg.stick_gain  = stick_gain_ff;
      cfg.load_yaw    = 1'b0;
      cfg.load_pitch  = 1'b0;
      cfg.start_yaw   = csr_bus.data[YAW_W-1:0];
      cfg.start_pitch = csr_bus.data[PITCH_W-1:0];
      if (csr_write) begin
         unique case (csr_idx_type'(csr_bus.index))
            CSR_CURSOR_GAIN: cfg.load_yaw = 1'b0;
            CSR_STICK_GAIN:  cfg.load_yaw = 1'b0;
            CSR_START_YAW:   cfg.load_yaw = 1'b1;
            CSR_START_PITCH: cfg.load_pitch = 1'b1;
            default:         cfg.load_yaw = 1'b0;
         endcase
      end
   end

   // Hold gain registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_gain_ff <= GAIN_W'(CURSOR_GAIN_RST);
         stick_gain_ff  <= GAIN_W'(STICK_GAIN_RST);
      end else if (csr_write) begin
         if (csr_idx_type'(csr_bus.index) == CSR_CURSOR_GAIN) begin
            cursor_gain_ff <= csr_bus.data;
         end
         if (csr_idx_type'(csr_bus.index) == CSR_STICK_GAIN) begin
            stick_gain_ff <= csr_bus.data;
         end
      end
   end

   ypld_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .q_full    (q_stat.full),
      .push      (push),
      .push_data (push_data)
   );

   ypld_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (q_stat)
   );

   ypld_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cord_start),
      .angle   (cord_angle),
      .stat    (cord_stat),
      .cos_q15 (cord_cos),
      .sin_q15 (cord_sin)
   );

   ypld_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pop_data   (pop_data),
      .q_empty    (q_stat.empty),
      .pop        (pop),
      .cord_start (cord_start),
      .cord_angle (cord_angle),
      .cord_stat  (cord_stat),
      .cord_cos   (cord_cos),
      .cord_sin   (cord_sin),
      .rsp        (rsp_bus)
   );

   // Checks on queue and CORDIC sequencing
   `ASSERT_NEVER(a_queue_no_overflow, clock, reset, q_stat.push && q_stat.full, "push into full queue")
   `ASSERT_NEVER(a_queue_no_underflow, clock, reset, q_stat.pop && q_stat.empty, "pop from empty queue")
   `ASSERT_NEVER(a_cordic_no_restart, clock, reset, cord_start && cord_stat.busy, "CORDIC started while busy")
   `ASSERT_PROP(a_cordic_done_idle, clock, reset, cord_stat.done |-> !cord_stat.busy, "CORDIC done while busy")

endmodule

`default_nettype wire

### bench/tb_yaw_pitch_look_direction_top.sv
// Self-checking testbench for the look-direction block: predicts every result and compares it.
`timescale 1ns / 1ps

module tb_yaw_pitch_look_direction_top;
   import ypld_pkg::*;

   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 5;
   localparam int PHASES         = 7;
   localparam int PHASE_ITEMS    = 250;
   localparam int DRAIN_CYCLES   = 64;
   localparam int WATCHDOG_LIMIT = 4000;

   // atan(2^-i) in 1/65536 degree
   localparam longint ARC_STEP [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   typedef struct packed {
      logic signed [YAW_W-1:0]   yaw;
      logic signed [PITCH_W-1:0] pitch;
      logic signed [DIR_W-1:0]   dir_x;
      logic signed [DIR_W-1:0]   dir_y;
      logic signed [DIR_W-1:0]   dir_z;
   } look_view_type;

   // Orientation predictor plus the queue of views still to arrive
   class look_scoreboard_type;
      longint        yaw_pos, pitch_pos, last_px, last_py;
      bit            first_move;
      longint        heading [3];
      longint        cursor_gain, stick_gain;
      look_view_type pending_views [$];
      int            errors;

      function new();
         cursor_gain = CURSOR_GAIN_RST;
         stick_gain  = STICK_GAIN_RST;
         yaw_pos     = YAW_RST;
         pitch_pos   = PITCH_RST;
         last_px     = 0;
         last_py     = 0;
         first_move  = 1'b1;
         errors      = 0;
         refresh_heading();
      endfunction

      function longint limit(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      // Q2.30 to Q1.15, ties up, clamped to the symmetric range
      function longint to_unit(longint v);
         return limit((v + 16384) >>> 15, -Q15_MAX, Q15_MAX);
      endfunction

      function longint mul_unit(longint a, longint b);
         return limit((a * b + 16384) >>> 15, -Q15_MAX, Q15_MAX);
      endfunction

      // Rotation-mode CORDIC on an angle in 1/64 degree
      function void sin_cos(longint a, output longint c, output longint s);
         longint x, y, z, nx;
         bit     flip;
         int     steps;
         x     = CORDIC_K;
         y     = 0;
         flip  = 1'b0;
         steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
         while (a > ANG_HALF) a -= ANG_FULL;
         while (a < -ANG_HALF) a += ANG_FULL;
         if (a > ANG_QUARTER) begin
            a -= ANG_HALF;
            flip = 1'b1;
         end else if (a < -ANG_QUARTER) begin
            a += ANG_HALF;
            flip = 1'b1;
         end
         z = a * 1024;
         for (int i = 0; i < steps; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               y  = y + (x >>> i);
               z  -= ARC_STEP[i];
            end else begin
               nx = x + (y >>> i);
               y  = y - (x >>> i);
               z  += ARC_STEP[i];
            end
            x = nx;
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         c = to_unit(x);
         s = to_unit(y);
      endfunction

      function void refresh_heading();
         longint cy, sy, cp, sp;
         sin_cos(yaw_pos, cy, sy);
         sin_cos(pitch_pos, cp, sp);
         heading[0] = mul_unit(cy, cp);
         heading[1] = sp;
         heading[2] = mul_unit(sy, cp);
      endfunction

      // Reduce a cursor coordinate to the position width
      function longint screen_pos(logic signed [VAL_W-1:0] v);
         longint p, span;
         p = longint'(v);
         if (POS_BITS < 16) begin
            span = longint'(1) << POS_BITS;
            p    = p & (span - 1);
            if (p >= span / 2) p -= span;
         end
         return p;
      endfunction

      // Saturate offsets, wrap yaw once, clamp pitch
      function void turn(longint dyaw, longint dpitch);
         dyaw    = limit(dyaw, -ANG_HALF, ANG_HALF);
         dpitch  = limit(dpitch, -ANG_HALF, ANG_HALF);
         yaw_pos += dyaw;
         if (yaw_pos > ANG_HALF) yaw_pos -= ANG_FULL;
         else if (yaw_pos < -ANG_HALF) yaw_pos += ANG_FULL;
         pitch_pos = limit(pitch_pos + dpitch, -PITCH_LIM, PITCH_LIM);
         refresh_heading();
      endfunction

      function void write_reg(csr_idx_type idx, logic [CSR_DAT_W-1:0] data);
         logic signed [YAW_W-1:0]   yaw_field;
         logic signed [PITCH_W-1:0] pitch_field;
         yaw_field   = data[YAW_W-1:0];
         pitch_field = data[PITCH_W-1:0];
         case (idx)
            CSR_CURSOR_GAIN: cursor_gain = data;
            CSR_STICK_GAIN:  stick_gain = data;
            CSR_START_YAW: begin
               yaw_pos = longint'(yaw_field);
               refresh_heading();
            end
            CSR_START_PITCH: begin
               pitch_pos = longint'(pitch_field);
               refresh_heading();
            end
         endcase
      endfunction

      // Advance the predicted state by one accepted command transaction
      function void note_command(cmd_type cmd, logic signed [VAL_W-1:0] xv,
                                 logic signed [VAL_W-1:0] yv);
         longint        px, py, dx, dy;
         look_view_type v;
         case (cmd)
            CMD_CURSOR: begin
               px = screen_pos(xv);
               py = screen_pos(yv);
               if (first_move) begin
                  last_px    = px;
                  last_py    = py;
                  first_move = 1'b0;
               end
               dx      = px - last_px;
               dy      = last_py - py;
               last_px = px;
               last_py = py;
               turn((dx * cursor_gain + CURSOR_RND) >>> CURSOR_SHIFT,
                    (dy * cursor_gain + CURSOR_RND) >>> CURSOR_SHIFT);
            end
            CMD_STICK: begin
               turn((longint'(xv) * stick_gain + STICK_RND) >>> STICK_SHIFT,
                    (-longint'(yv) * stick_gain + STICK_RND) >>> STICK_SHIFT);
            end
            CMD_SET_LAST: begin
               last_px = screen_pos(xv);
               last_py = screen_pos(yv);
            end
            default: refresh_heading();
         endcase
         v.yaw   = YAW_W'(yaw_pos);
         v.pitch = PITCH_W'(pitch_pos);
         v.dir_x = DIR_W'(heading[0]);
         v.dir_y = DIR_W'(heading[1]);
         v.dir_z = DIR_W'(heading[2]);
         pending_views.push_back(v);
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(look_view_type got);
         look_view_type want;
         if (pending_views.size() == 0) begin
            $display("%0t: unexpected result transaction, yaw %0d pitch %0d", $time,
                     got.yaw, got.pitch);
            errors++;
            return;
         end
         want = pending_views.pop_front();
         compare_field("yaw_out", want.yaw, got.yaw);
         compare_field("pitch_out", want.pitch, got.pitch);
         compare_field("dir_x", want.dir_x, got.dir_x);
         compare_field("dir_y", want.dir_y, got.dir_y);
         compare_field("dir_z", want.dir_z, got.dir_z);
      endfunction

      function int outstanding();
         return pending_views.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   ypld_req_if req_bus ();
   ypld_rsp_if rsp_bus ();
   ypld_csr_if csr_bus ();

   yaw_pitch_look_direction_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   look_scoreboard_type     sb;
   bit                      steady;
   int                      stall_left;
   int                      idle_cycles;
   logic signed [VAL_W-1:0] cursor_x, cursor_y;

   always #HALF_PERIOD clock = ~clock;

   // Mostly short gaps, a few long ones; none while steady
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Stall the result channel at random
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         stall_left = pick_gap();
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Check each accepted result transaction
   always @(posedge clock) begin
      look_view_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.yaw   = rsp_bus.yaw_out;
         got.pitch = rsp_bus.pitch_out;
         got.dir_x = rsp_bus.dir_x;
         got.dir_y = rsp_bus.dir_y;
         got.dir_z = rsp_bus.dir_z;
         sb.check_result(got);
      end
   end

   // End the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_command(cmd_type cmd, logic signed [VAL_W-1:0] xv,
                               logic signed [VAL_W-1:0] yv);
      int gap;
      gap = pick_gap();
      for (int i = 0; i < gap; i++) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid   <= 1'b1;
      req_bus.cmd     <= cmd;
      req_bus.x_value <= xv;
      req_bus.y_value <= yv;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_command(cmd, xv, yv);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Drop the command valid and hold until every result has come back
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [CSR_DAT_W-1:0] pick_gain();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return CSR_DAT_W'($urandom_range(0, 2048));
         default: return CSR_DAT_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [VAL_W-1:0] corner_value();
      case ($urandom_range(0, 3))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         default: return 16'shFFFF;
      endcase
   endfunction

   // Retune gains and sometimes reload the start angles between phases
   task automatic retune();
      write_reg(CSR_CURSOR_GAIN, pick_gain());
      write_reg(CSR_STICK_GAIN, pick_gain());
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 5))
            0:       write_reg(CSR_START_YAW, CSR_DAT_W'(ANG_HALF));
            1:       write_reg(CSR_START_YAW, CSR_DAT_W'(-ANG_HALF));
            2:       write_reg(CSR_START_YAW, 16'h4000);
            3:       write_reg(CSR_START_YAW, 16'hBFFF);
            default: write_reg(CSR_START_YAW, CSR_DAT_W'($urandom));
         endcase
      end
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 5))
            0:       write_reg(CSR_START_PITCH, CSR_DAT_W'(PITCH_LIM));
            1:       write_reg(CSR_START_PITCH, CSR_DAT_W'(-PITCH_LIM));
            2:       write_reg(CSR_START_PITCH, 16'h2000);
            3:       write_reg(CSR_START_PITCH, 16'hDFFF);
            default: write_reg(CSR_START_PITCH, CSR_DAT_W'($urandom));
         endcase
      end
   endtask

   // Mostly cursor drags near the last position and stick moves, plus noise
   task automatic send_random();
      int                      pick;
      cmd_type                 cmd;
      logic signed [VAL_W-1:0] xv, yv;
      pick = $urandom_range(0, 99);
      if (pick < 35) cmd = CMD_CURSOR;
      else if (pick < 70) cmd = CMD_STICK;
      else if (pick < 80) cmd = CMD_SET_LAST;
      else cmd = CMD_REFRESH;
      xv = VAL_W'($urandom);
      yv = VAL_W'($urandom);
      case (cmd)
         CMD_CURSOR, CMD_SET_LAST: begin
            if ($urandom_range(0, 9) < 7) begin
               xv = cursor_x + VAL_W'($urandom_range(0, 400)) - VAL_W'(200);
               yv = cursor_y + VAL_W'($urandom_range(0, 400)) - VAL_W'(200);
            end
            cursor_x = xv;
            cursor_y = yv;
         end
         CMD_STICK: begin
            if ($urandom_range(0, 9) < 2) begin
               xv = corner_value();
               yv = corner_value();
            end
         end
         default: ;
      endcase
      send_command(cmd, xv, yv);
   endtask

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.cmd     = CMD_REFRESH;
      req_bus.x_value = '0;
      req_bus.y_value = '0;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = CSR_CURSOR_GAIN;
      csr_bus.data    = '0;
      steady          = 1'b0;
      stall_left      = 0;
      idle_cycles     = 0;
      cursor_x        = '0;
      cursor_y        = '0;
      sb              = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset direction, first move after a set-last, saturating drags
      send_command(CMD_REFRESH, 16'sd0, 16'sd0);
      send_command(CMD_SET_LAST, 16'sd300, 16'sd400);
      send_command(CMD_CURSOR, 16'sd1000, -16'sd500);
      send_command(CMD_CURSOR, 16'sd1005, -16'sd510);
      send_command(CMD_CURSOR, 16'sh7FFF, 16'sh7FFF);
      send_command(CMD_CURSOR, 16'sh8000, 16'sh8000);
      send_command(CMD_SET_LAST, 16'sd0, 16'sd0);
      send_command(CMD_CURSOR, 16'sd3, -16'sd2);
      // Full stick deflection: pitch clamps, yaw wraps
      repeat (3) send_command(CMD_STICK, 16'sh7FFF, 16'sh8000);
      repeat (3) send_command(CMD_STICK, 16'sh8000, 16'sh7FFF);
      send_command(CMD_STICK, 16'sd0, 16'sd0);
      send_command(CMD_STICK, -16'sd1, 16'sd1);
      send_command(CMD_REFRESH, 16'sh5A5A, 16'shA5A5);

      // Out-of-range start angles, zero and full-scale gains
      wait_idle();
      write_reg(CSR_START_YAW, 16'h4000);
      write_reg(CSR_START_PITCH, 16'h2000);
      write_reg(CSR_CURSOR_GAIN, 16'hFFFF);
      write_reg(CSR_STICK_GAIN, 16'h0000);
      send_command(CMD_REFRESH, 16'sd0, 16'sd0);
      send_command(CMD_SET_LAST, -16'sd100, 16'sd100);
      send_command(CMD_STICK, 16'sh7FFF, 16'sh7FFF);
      send_command(CMD_CURSOR, -16'sd90, 16'sd110);
      wait_idle();
      write_reg(CSR_START_YAW, 16'hBFFF);
      write_reg(CSR_START_PITCH, 16'hDFFF);
      write_reg(CSR_CURSOR_GAIN, 16'h0000);
      write_reg(CSR_STICK_GAIN, 16'hFFFF);
      send_command(CMD_REFRESH, 16'sd0, 16'sd0);
      send_command(CMD_STICK, 16'sh7FFF, 16'sh8000);
      send_command(CMD_CURSOR, 16'sd7, 16'sd7);

      // Random phases, each with fresh settings
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         retune();
         steady = (p % 3 == 1);
         for (int n = 0; n < PHASE_ITEMS; n++) send_random();
      end

      steady = 1'b0;
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
